FILE: rtl/spi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_pkg
// Shared types and constants of the sphere / plane immersion pipeline.
// ----------------------------------------------------------------------------
package spi_pkg;

  localparam int FracBits   = 16;
  localparam int NormalBits = 14;
  localparam int QuoWidth   = 25;
  localparam int NumWidth   = 52;
  localparam int DenWidth   = 28;

  // constants with 32 fractional bits
  localparam logic [33:0] KPi    = 34'd13493037705;
  localparam logic [34:0] KPi4_3 = 35'd17990716939;
  localparam logic [35:0] KPi4   = 36'd53972150818;
  localparam logic [34:0] KPi2   = 35'd26986075409;
  localparam logic [34:0] KPi_3  = 35'd4497679235;

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic        [23:0] sphere_radius;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] plane_offset;
  } in_word_t;

  typedef struct packed {
    logic               immersed;
    logic        [47:0] immersed_volume;
    logic        [39:0] wetted_area;
    logic        [39:0] projected_area;
    logic signed [31:0] buoyancy_x;
    logic signed [31:0] buoyancy_y;
    logic signed [31:0] buoyancy_z;
  } out_word_t;

  // result fields carried alongside the divider
  typedef struct packed {
    logic             imm;
    logic             full;
    logic [47:0]      vol;
    logic [39:0]      area;
    logic [39:0]      proj;
    logic [2:0][31:0] c;
    logic [2:0][15:0] n;
  } side_t;

endpackage

FILE: rtl/spi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module spi_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [spi_pkg::NumWidth-1:0]  num_i,
  input  logic [spi_pkg::DenWidth-1:0]  den_i,
  input  spi_pkg::side_t                side_i,
  output logic                          valid_o,
  output logic [spi_pkg::QuoWidth-1:0]  quo_o,
  output spi_pkg::side_t                side_o
);

  localparam int QW = spi_pkg::QuoWidth;
  localparam int NW = spi_pkg::NumWidth;
  localparam int DW = spi_pkg::DenWidth;

  logic [QW-1:0]         v_q;
  logic [QW-1:0][NW-1:0] rem_q;
  logic [QW-1:0][QW-1:0] quo_q;
  logic [QW-1:0][DW-1:0] den_q;
  spi_pkg::side_t        side_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic                v_in;
    logic [NW-1:0]       rem_in;
    logic [QW-1:0]       quo_in;
    logic [DW-1:0]       den_in;
    spi_pkg::side_t      side_in;
    logic [NW:0]         dsh;
    logic                ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign dsh = {{(NW+1-DW){1'b0}}, den_in} << (QW-1-k);
    assign ge  = {1'b0, rem_in} >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? (rem_in - dsh[NW-1:0]) : rem_in;
        quo_q[k]  <= {quo_in[QW-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

FILE: rtl/sphere_plane_immersion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_plane_immersion
// Volume, wetted area, projected area and buoyancy point of a sphere cut by
// a fluid plane, Q.16 fixed point, one word per cycle while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i takes one sphere and
//   plane per word. Output channel out_valid_o / out_stall_i / out_data_o
//   returns one result word per input word, in order.
//   Config channel cfg_valid_i / cfg_ready_o / cfg_wdata_i writes the volume
//   threshold; ready is always high. Write it only while the pipeline is empty.
//   One word per cycle while not stalled. The pipeline has seven arithmetic
//   stages, a 25-stage divider for the buoyancy shift, one multiply stage and
//   the output register.
//   Reset empties the pipeline and clears the threshold to zero.
//   While the output word is held by out_stall_i the whole pipeline freezes
//   and in_stall_o rises; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module sphere_plane_immersion (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  spi_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output spi_pkg::out_word_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [47:0]        cfg_wdata_i
);

  logic en;
  logic [47:0] thr_q;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v9_q <= 1'b0;
      v10_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q; v9_q <= v8_q;
      v10_q <= v9_q;
    end
  end

  // stage 1: normal times center
  logic [2:0][31:0]   c1_q, c2_q, c3_q, c4_q, c5_q, c6_q;
  logic [2:0][15:0]   n1_q, n2_q, n3_q, n4_q, n5_q, n6_q;
  logic signed [47:0] p1_q [3];
  logic [31:0]        d1_q;
  logic [23:0]        r1_q, r2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q    <= {in_data_i.center_z, in_data_i.center_y, in_data_i.center_x};
      n1_q    <= {in_data_i.normal_z, in_data_i.normal_y, in_data_i.normal_x};
      p1_q[0] <= 48'(in_data_i.normal_x) * 48'(in_data_i.center_x);
      p1_q[1] <= 48'(in_data_i.normal_y) * 48'(in_data_i.center_y);
      p1_q[2] <= 48'(in_data_i.normal_z) * 48'(in_data_i.center_z);
      d1_q    <= in_data_i.plane_offset;
      r1_q    <= in_data_i.sphere_radius;
    end
  end

  // stage 2: depth and case split
  logic signed [49:0] dot;
  logic signed [37:0] zi, zsum, zdif, ri;

  assign dot  = 50'(p1_q[0]) + 50'(p1_q[1]) + 50'(p1_q[2]);
  assign ri   = {14'b0, r1_q};
  assign zi   = {{6{d1_q[31]}}, d1_q} - {{2{dot[49]}}, dot[49:spi_pkg::NormalBits]};
  assign zsum = zi + ri;
  assign zdif = ri - zi;

  logic        out2_q, full2_q;
  logic [24:0] ma2_q, t2m2_q;
  logic [25:0] mb2_q, t32_q;
  logic [37:0] t3w;

  assign t3w = zdif + ri;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q    <= c1_q;
      n2_q    <= n1_q;
      r2_q    <= r1_q;
      out2_q  <= zsum[37] || (zsum == '0);
      full2_q <= zdif[37] || (zdif == '0);
      ma2_q   <= (zdif[37] || (zdif == '0)) ? {1'b0, r1_q} : zsum[24:0];
      mb2_q   <= (zdif[37] || (zdif == '0)) ? {2'b0, r1_q} : t3w[25:0];
      t2m2_q  <= zdif[24:0];
      t32_q   <= t3w[25:0];
    end
  end

  // stage 3: squares and radius product
  logic        out3_q, full3_q;
  logic [49:0] sq3_q, t2sq3_q;
  logic [48:0] a23_q;
  logic [25:0] b3_q, t33_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_q    <= c2_q;
      n3_q    <= n2_q;
      out3_q  <= out2_q;
      full3_q <= full2_q;
      sq3_q   <= 50'(ma2_q) * 50'(ma2_q);
      a23_q   <= 49'(r2_q) * 49'(ma2_q);
      t2sq3_q <= 50'(t2m2_q) * 50'(t2m2_q);
      b3_q    <= mb2_q;
      t33_q   <= t32_q;
    end
  end

  // stage 4: partial products
  logic        out4_q, full4_q;
  logic [50:0] pal4_q, pah4_q;
  logic [60:0] arl4_q;
  logic [59:0] arh4_q;
  logic [58:0] pjl4_q, pjh4_q;
  logic [51:0] num4_q, num5_q, num6_q;
  logic [27:0] den4_q, den5_q, den6_q;
  logic [35:0] k2;

  assign k2 = full3_q ? spi_pkg::KPi4 : {1'b0, spi_pkg::KPi2};

  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_q    <= c3_q;
      n4_q    <= n3_q;
      out4_q  <= out3_q;
      full4_q <= full3_q;
      pal4_q  <= 51'(sq3_q[24:0]) * 51'(b3_q);
      pah4_q  <= 51'(sq3_q[49:25]) * 51'(b3_q);
      arl4_q  <= 61'(k2) * 61'(a23_q[24:0]);
      arh4_q  <= 60'(k2) * 60'(a23_q[48:25]);
      pjl4_q  <= 59'(spi_pkg::KPi) * 59'(sq3_q[24:0]);
      pjh4_q  <= 59'(spi_pkg::KPi) * 59'(sq3_q[49:25]);
      num4_q  <= {1'b0, t2sq3_q, 1'b0} + {2'b0, t2sq3_q};
      den4_q  <= {t33_q, 2'b00};
    end
  end

  // stage 5: recombine
  logic [76:0] psum;
  logic [85:0] asum;
  logic [84:0] jsum;

  assign psum = {1'b0, pah4_q, 25'b0} + {26'b0, pal4_q};
  assign asum = {1'b0, arh4_q, 25'b0} + {25'b0, arl4_q};
  assign jsum = {1'b0, pjh4_q, 25'b0} + {26'b0, pjl4_q};

  logic        out5_q, full5_q, out6_q, full6_q;
  logic [43:0] p5_q;
  logic [39:0] area5_q, proj5_q, area6_q, proj6_q;
  logic [34:0] kv5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c5_q    <= c4_q;
      n5_q    <= n4_q;
      out5_q  <= out4_q;
      full5_q <= full4_q;
      p5_q    <= psum[75:32];
      area5_q <= {3'b0, asum[84:48]};
      proj5_q <= full4_q ? {4'b0, jsum[83:48]} : '0;
      kv5_q   <= full4_q ? spi_pkg::KPi4_3 : spi_pkg::KPi_3;
      num5_q  <= num4_q;
      den5_q  <= den4_q;
    end
  end

  // stage 6: volume partial products
  logic [56:0] vl6_q, vh6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c6_q    <= c5_q;
      n6_q    <= n5_q;
      out6_q  <= out5_q;
      full6_q <= full5_q;
      vl6_q   <= 57'(kv5_q) * 57'(p5_q[21:0]);
      vh6_q   <= 57'(kv5_q) * 57'(p5_q[43:22]);
      area6_q <= area5_q;
      proj6_q <= proj5_q;
      num6_q  <= num5_q;
      den6_q  <= den5_q;
    end
  end

  // stage 7: volume and threshold
  logic [79:0]    vsum;
  spi_pkg::side_t side7_d, side7_q, side8;
  logic [51:0]    num7_q;
  logic [27:0]    den7_q;

  assign vsum = {1'b0, vh6_q, 22'b0} + {23'b0, vl6_q};

  always_comb begin
    side7_d.imm  = !out6_q && (vsum[79:32] > thr_q);
    side7_d.full = full6_q;
    side7_d.vol  = vsum[79:32];
    side7_d.area = area6_q;
    side7_d.proj = proj6_q;
    side7_d.c    = c6_q;
    side7_d.n    = n6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side7_q <= side7_d;
      num7_q  <= num6_q;
      den7_q  <= den6_q;
    end
  end

  // buoyancy shift divider
  logic [spi_pkg::QuoWidth-1:0] quo;

  spi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (num7_q),
    .den_i   (den7_q),
    .side_i  (side7_q),
    .valid_o (v8_q),
    .quo_o   (quo),
    .side_o  (side8)
  );

  // stage 9: normal times shift
  logic [24:0]        sh;
  logic signed [41:0] bp9_q [3];
  spi_pkg::side_t     side9_q;

  assign sh = side8.full ? '0 : quo;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side9_q <= side8;
      for (int i = 0; i < 3; i++) begin
        bp9_q[i] <= 42'($signed(side8.n[i])) * 42'($signed({1'b0, sh}));
      end
    end
  end

  // output register
  logic signed [33:0] bdif [3];
  logic [2:0][31:0]   bsat;
  spi_pkg::out_word_t out_d, out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bdif[i] = {{2{side9_q.c[i][31]}}, side9_q.c[i]}
              - {{6{bp9_q[i][41]}}, bp9_q[i][41:spi_pkg::NormalBits]};
      if (bdif[i] > 34'sh0_7FFF_FFFF) begin
        bsat[i] = 32'h7FFF_FFFF;
      end else if (bdif[i] < -34'sh0_8000_0000) begin
        bsat[i] = 32'h8000_0000;
      end else begin
        bsat[i] = bdif[i][31:0];
      end
    end
    out_d = '0;
    if (side9_q.imm) begin
      out_d.immersed        = 1'b1;
      out_d.immersed_volume = side9_q.vol;
      out_d.wetted_area     = side9_q.area;
      out_d.projected_area  = side9_q.proj;
      out_d.buoyancy_x      = bsat[0];
      out_d.buoyancy_y      = bsat[1];
      out_d.buoyancy_z      = bsat[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v10_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/spi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_checker
// Port-level checks of the sphere / plane immersion pipeline.
// ----------------------------------------------------------------------------
module spi_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input spi_pkg::out_word_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output word changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  a_dry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.immersed |->
      out_data_o.immersed_volume == '0 && out_data_o.wetted_area == '0 &&
      out_data_o.projected_area == '0 && out_data_o.buoyancy_x == '0 &&
      out_data_o.buoyancy_y == '0 && out_data_o.buoyancy_z == '0)
    else $error("dry word has nonzero fields");

  a_wet_vol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.immersed |-> out_data_o.immersed_volume != '0)
    else $error("immersed word with zero volume");

endmodule

bind sphere_plane_immersion spi_checker u_spi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
